FILE: rtl/assert_macros.svh
// Assertion macros used by the top level RTL file of the block pool allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fbpa_pkg.sv
// Package with the codes, limits and types of the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

   // Request opcodes carried on req_tuser.
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_POOL_BASE   = 2'd0,
      CSR_BLOCK_SHIFT = 2'd1,
      CSR_BLOCK_COUNT = 2'd2
   } csr_index_type;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   // Field widths of the words on the ports.
   localparam int unsigned SIZE_W  = 32;
   localparam int unsigned FADDR_W = 32;
   localparam int unsigned FREE_W  = 7;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned BCNT_W  = 7;

   // Usable range of the block shift, its reset value and the reset value of the block count.
   localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd3;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd4;
   localparam logic [BCNT_W-1:0]  COUNT_RST = 7'd64;

endpackage

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: LIFO free list in a link memory.
//
//   Channel   Direction  Handshake              Word
//   req_      in         req_tvalid/req_tready  tdata: req_size, block_addr; tuser: opcode
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: result_addr, free_blocks; tuser: status
//   csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// Each request is accepted in the idle state and then runs an execute step,
// which needs the link memory read of the head block: it is issued from the
// head register and registered in rd_link_ff for the execute step.
// The response register lets a new request be accepted while a response
// waits; a stalled response holds the execute step until it is taken.
// After reset and after every write to a defined register index a clearing
// pass re-chains all MAX_BLOCKS link memory entries, with req_tready low.
// csr_ready is always high.
`default_nettype none
`include "assert_macros.svh"

module fixed_block_pool_allocator_top
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = 64,
   parameter int ADDR_BITS  = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // [31:0] req_size, [63:32] block_addr
   input  wire logic [1:0]   req_tuser,   // [1:0] opcode
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [39:0]       rsp_tdata,   // [31:0] result_addr, [38:32] free_blocks, pad
   output logic [0:0]        rsp_tuser,   // [0] status
   // Configuration write channel.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   // Derived widths.
   localparam int IW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CMPW  = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;
   localparam int CW    = (ADDR_BITS > 32) ? ADDR_BITS : 32;
   localparam logic [CW-1:0] AMASK = {CW{1'b1}} >> (CW - ADDR_BITS);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BLOCKS - 1);

   // Control registers.
   state_type            state_ff, state_in;
   logic [IW-1:0]        clr_idx_ff, clr_idx_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]     free_count_ff, free_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          pool_base_ff, pool_base_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [BCNT_W-1:0]    count_ff, count_in;

   // Payload registers.
   logic [1:0]           op_ff;
   logic                 size_ok_ff;
   logic [CW-1:0]        offset_ff;
   logic                 rsp_status_ff;
   logic [FADDR_W-1:0]   rsp_addr_ff;
   logic [FREE_W-1:0]    rsp_free_ff;
   logic [IW-1:0]        rd_link_ff;

   // Link memory.
   logic [IW-1:0]        link_mem [MAX_BLOCKS];
   logic                 mem_we;
   logic [IW-1:0]        mem_wa;
   logic [IW-1:0]        mem_wd;

   // Combinational terms.
   logic                 req_fire;
   logic                 csr_fire;
   logic                 exec_go;
   logic [SHIFT_W-1:0]   sh_eff;
   logic [CNT_W-1:0]     n_eff;
   logic [SIZE_W-1:0]    bsize;
   logic [CW-1:0]        bmask;
   logic [CW-1:0]        psize;
   logic [CW-1:0]        psize_last;
   logic [CW-1:0]        offset_in;
   logic [IW:0]          clr_next;
   logic [IW-1:0]        clr_link;
   logic                 clr_last;
   logic [IW-1:0]        free_idx;
   logic [CW-1:0]        alloc_addr;
   logic                 exec_status;
   logic [FADDR_W-1:0]   exec_addr;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid & req_tready;
   assign csr_fire   = csr_valid & csr_ready;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Effective shift and count, clamped to their usable ranges.
   always_comb begin
      priority if (shift_ff < SHIFT_MIN) begin
         sh_eff = SHIFT_MIN;
      end else if (shift_ff > SHIFT_MAX) begin
         sh_eff = SHIFT_MAX;
      end else begin
         sh_eff = shift_ff;
      end
      priority if (count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (CMPW'(count_ff) > CMPW'(MAX_BLOCKS)) begin
         n_eff = CNT_W'(MAX_BLOCKS);
      end else begin
         n_eff = CNT_W'(count_ff);
      end
   end

   // Block and pool sizes follow from the configuration alone.
   assign bsize      = SIZE_W'(1) << sh_eff;
   assign bmask      = CW'(bsize) - CW'(1);
   assign psize      = CW'(n_eff) << sh_eff;
   assign psize_last = psize - CW'(bsize);

   // Byte offset from the pool base, wrapped to the address width.
   assign offset_in  = (CW'(req_tdata[63:32]) - CW'(pool_base_ff)) & AMASK;

   // Link value written by the clearing pass: the next index, or zero at the end.
   assign clr_next = {1'b0, clr_idx_ff} + (IW+1)'(1);
   assign clr_link = (clr_next < (IW+1)'(n_eff)) ? clr_next[IW-1:0] : '0;
   assign clr_last = (clr_idx_ff == LAST_IDX);

   // Addresses of the execute step.
   assign free_idx   = IW'(offset_ff >> sh_eff);
   assign alloc_addr = (CW'(pool_base_ff) + (CW'(head_ff) << sh_eff)) & AMASK;

   // Sequencer, free list update and configuration writes.
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      head_in       = head_ff;
      free_count_in = free_count_ff;
      pool_base_in  = pool_base_ff;
      shift_in      = shift_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      mem_we        = 1'b0;
      mem_wa        = clr_idx_ff;
      mem_wd        = clr_link;
      exec_status   = 1'b1;
      exec_addr     = '0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // rd_link_ff holds the link of the current head: the head last changed
            // before this request was accepted, and acceptance does not change it.
            unique case (op_ff)
               OP_ALLOC: begin
                  if (size_ok_ff && (free_count_ff != '0)) begin
                     exec_status = 1'b0;
                     exec_addr   = alloc_addr[FADDR_W-1:0];
                  end
               end
               OP_FREE: begin
                  if (size_ok_ff && (offset_ff < psize) && ((offset_ff & bmask) == '0)
                      && (free_count_ff < n_eff)) begin
                     exec_status = 1'b0;
                  end
               end
               OP_QUERY: begin
                  if (size_ok_ff && (offset_ff <= psize_last)) begin
                     exec_status = 1'b0;
                  end
               end
               default: begin
                  exec_status = 1'b1;
               end
            endcase
            if (exec_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (!exec_status && (op_ff == OP_ALLOC)) begin
                  head_in       = rd_link_ff;
                  free_count_in = free_count_ff - CNT_W'(1);
               end
               if (!exec_status && (op_ff == OP_FREE)) begin
                  mem_we        = 1'b1;
                  mem_wa        = free_idx;
                  mem_wd        = head_ff;
                  head_in       = free_idx;
                  free_count_in = free_count_ff + CNT_W'(1);
               end
            end
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_last) begin
               state_in      = ST_IDLE;
               free_count_in = n_eff;
            end else begin
               clr_idx_in = clr_idx_ff + IW'(1);
            end
         end
         default: begin
            state_in   = ST_CLEAR;
            clr_idx_in = '0;
         end
      endcase

      // A write to a defined register index re-chains the whole pool.
      if (csr_fire) begin
         unique case (csr_index)
            CSR_POOL_BASE: begin
               pool_base_in = csr_data;
               state_in     = ST_CLEAR;
            end
            CSR_BLOCK_SHIFT: begin
               shift_in = csr_data[SHIFT_W-1:0];
               state_in = ST_CLEAR;
            end
            CSR_BLOCK_COUNT: begin
               count_in = csr_data[BCNT_W-1:0];
               state_in = ST_CLEAR;
            end
            default: begin
               pool_base_in = pool_base_ff;
            end
         endcase
         if (state_in == ST_CLEAR) begin
            clr_idx_in = '0;
            head_in    = '0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         head_ff       <= '0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pool_base_ff  <= '0;
         shift_ff      <= SHIFT_RST;
         count_ff      <= COUNT_RST;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         head_ff       <= head_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pool_base_ff  <= pool_base_in;
         shift_ff      <= shift_in;
         count_ff      <= count_in;
      end
   end

   // Request capture and response register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff      <= req_tuser;
         size_ok_ff <= (req_tdata[31:0] == bsize);
         offset_ff  <= offset_in;
      end
      if (exec_go) begin
         rsp_status_ff <= exec_status;
         rsp_addr_ff   <= exec_addr;
         rsp_free_ff   <= FREE_W'(free_count_in);
      end
   end

   // Link memory: one write port, one registered read at the head.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wa] <= mem_wd;
      end
      rd_link_ff <= link_mem[head_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_free_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

   // An accepted request goes straight to execute unless a defined register is written.
   `ASSERT_NXT(a_accept_exec, clock, reset, req_fire && !csr_fire, state_ff == ST_EXEC, "accept did not lead to execute")
   // The free list never holds more blocks than the pool has.
   `ASSERT_IMP(a_count_bound, clock, reset, state_ff != ST_CLEAR, free_count_ff <= n_eff, "free count above pool size")
   // An execute step always leaves a response behind.
   `ASSERT_NXT(a_exec_rsp, clock, reset, exec_go, rsp_valid_ff, "execute produced no response")
   // The clearing pass ends idle with the head on block zero.
   `ASSERT_NXT(a_clear_end, clock, reset, (state_ff == ST_CLEAR) && clr_last && !csr_fire, (state_ff == ST_IDLE) && (head_ff == '0), "clearing pass ended badly")

endmodule

`default_nettype wire
